// ===== hw/rtl/mpw_pkg.sv =====
// ----------------------------------------------------------------------------
// mpw_pkg
// Shared types and constants for the MODWT forward pyramid step.
// ----------------------------------------------------------------------------
`default_nettype none

package mpw_pkg;

    // Fixed field widths.
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 15;
    localparam int POS_W     = 10;
    localparam int REQ_W     = 2;
    localparam int SLEN_W    = 11;
    localparam int LVL_W     = 4;
    localparam int TAPC_W    = 5;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int CNT_W     = 4;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_COEF    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

    // Register indexes (word address bits of paddr).
    localparam logic [1:0] CFG_SERIES = 2'd0;
    localparam logic [1:0] CFG_LEVEL  = 2'd1;
    localparam logic [1:0] CFG_TAPS   = 2'd2;

    // Register reset values.
    localparam logic [SLEN_W-1:0] SLEN_RST = 11'd1024;
    localparam logic [LVL_W-1:0]  LVL_RST  = 4'd1;
    localparam logic [TAPC_W-1:0] TAPC_RST = 5'd2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_STEP  = 7'b0000010,
        ST_POS   = 7'b0000100,
        ST_NEG   = 7'b0001000,
        ST_WALK  = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_ROUND = 7'b1000000
    } state_t;

    typedef struct packed {
        logic clear;
        logic issue;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/modwt_forward_pyramid_step.sv =====
// ----------------------------------------------------------------------------
// modwt_forward_pyramid_step
// One forward level of the MODWT pyramid: loads taps and samples, and for a
// compute beat returns the circular scaling and wavelet sums at a position.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ----------------------------------
//  apb       in/out     psel/penable/pready    paddr, pwdata, prdata
//  in        in         in_valid / in_stall    req_type, index, sample, g/h_coef
//  out       out        out_valid / out_stall  position, scaling/wavelet_out,
//                                              saturated
//
//  Load beats do not make the block busy; it stays ready for the next beat.
//  A compute beat first reduces the tap spacing modulo N, then the position,
//  runs a setup step, takes one tap per cycle on the shared
//  multiply-accumulate pair, drains it and rounds. All modulo work runs on
//  one shared modular adder.
//  A stalled output holds the round step until the output register frees.
//  Reset restores the configuration registers; stores are undefined until
//  written.
//
`default_nettype none

module modwt_forward_pyramid_step #(
    parameter int MAX_SERIES   = 1024,
    parameter int MAX_TAPS     = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mpw_pkg::APB_AW-1:0]        paddr,
    input  wire logic [mpw_pkg::APB_DW-1:0]        pwdata,
    output logic      [mpw_pkg::APB_DW-1:0]        prdata,
    output logic                                   pready,
    // Request channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [mpw_pkg::REQ_W-1:0]         req_type,
    input  wire logic [mpw_pkg::POS_W-1:0]         index,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    sample,
    input  wire logic signed [mpw_pkg::COEF_W-1:0] g_coef,
    input  wire logic signed [mpw_pkg::COEF_W-1:0] h_coef,
    // Result channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [mpw_pkg::POS_W-1:0]         position,
    output logic signed [SAMPLE_WIDTH-1:0]         scaling_out,
    output logic signed [SAMPLE_WIDTH-1:0]         wavelet_out,
    output logic                                   saturated
);

    import mpw_pkg::*;

    // The series length register is 11 bits, which caps the usable N.
    localparam int SLEN_MAX = (1 << SLEN_W) - 1;
    localparam int N_MAX    = (MAX_SERIES < SLEN_MAX) ? MAX_SERIES : SLEN_MAX;
    localparam int NW       = $clog2(N_MAX + 1);
    localparam int KW       = $clog2(N_MAX);
    localparam int SA_W     = $clog2(MAX_SERIES);
    localparam int TA_W     = $clog2(MAX_TAPS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SLEN_W-1:0] slen_reg;
    logic [LVL_W-1:0]  level_reg;
    logic [TAPC_W-1:0] tapc_reg;
    logic              cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slen_reg  <= SLEN_RST;
            level_reg <= LVL_RST;
            tapc_reg  <= TAPC_RST;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                CFG_SERIES: slen_reg  <= pwdata[SLEN_W-1:0];
                CFG_LEVEL:  level_reg <= pwdata[LVL_W-1:0];
                CFG_TAPS:   tapc_reg  <= pwdata[TAPC_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            CFG_SERIES: prdata = APB_DW'(slen_reg);
            CFG_LEVEL:  prdata = APB_DW'(level_reg);
            CFG_TAPS:   prdata = APB_DW'(tapc_reg);
            default:    prdata = '0;
        endcase
    end

    // Effective settings: out-of-range values are clamped to the legal range.
    logic [NW-1:0]    n_eff;
    logic [LVL_W-1:0] lv_eff;
    logic [TA_W-1:0]  taps_m1_eff;

    always_comb
    begin
        if (slen_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(slen_reg) > MAX_SERIES)
        begin
            n_eff = NW'(MAX_SERIES);
        end
        else
        begin
            n_eff = NW'(slen_reg);
        end

        lv_eff = (level_reg == '0) ? LVL_W'(1) : level_reg;

        if (tapc_reg == '0)
        begin
            taps_m1_eff = '0;
        end
        else if (32'(tapc_reg) > MAX_TAPS)
        begin
            taps_m1_eff = TA_W'(MAX_TAPS - 1);
        end
        else
        begin
            taps_m1_eff = TA_W'(tapc_reg - TAPC_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    state_t            state_reg,   state_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic              first_reg,   first_next;
    logic [POS_W-1:0]  idx_reg,     idx_next;
    logic [NW-1:0]     n_reg,       n_next;
    logic [TA_W-1:0]   taps_m1_reg, taps_m1_next;
    logic [KW-1:0]     r_reg,       r_next;
    logic [KW-1:0]     step_reg,    step_next;
    logic [NW-1:0]     nstep_reg,   nstep_next;
    logic [KW-1:0]     k_reg,       k_next;
    logic [KW-1:0]     t_reg,       t_next;
    logic [TA_W-1:0]   l_reg,       l_next;

    logic                    out_valid_reg, out_valid_next;
    logic [POS_W-1:0]        pos_reg,       pos_next;
    logic [SAMPLE_WIDTH-1:0] v_reg,         v_next;
    logic [SAMPLE_WIDTH-1:0] w_reg,         w_next;
    logic                    sat_reg,       sat_next;

    logic in_acc;
    logic out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid & ~in_stall;
    assign out_free = ~out_valid_reg | ~out_stall;

    // ------------------------------------------------------------------
    // Shared modular adder. In the reduce phases it computes
    // (2r + bit) mod n, feeding the exponent bits of 2^(level-1) and then
    // the position bits most significant first. While walking the taps it
    // steps the sample index back by tau modulo n as k + (n - step).
    // ------------------------------------------------------------------
    logic          dig_bit;
    logic [KW-1:0] am_a;
    logic [NW-1:0] am_b;
    logic [KW-1:0] am_res;

    assign dig_bit = (state_reg == ST_STEP) ? first_reg : idx_reg[POS_W-1];
    assign am_a    = (state_reg == ST_WALK) ? k_reg : r_reg;
    assign am_b    = (state_reg == ST_WALK) ? nstep_reg
                                            : NW'(r_reg) + NW'(dig_bit);

    mpw_addmod #(
        .KW (KW),
        .NW (NW)
    ) u_addmod (
        .a   (am_a),
        .b   (am_b),
        .n   (n_reg),
        .res (am_res)
    );

    // ------------------------------------------------------------------
    // Stores and multiply-accumulate
    // ------------------------------------------------------------------
    logic [31:0]                idx_ext;
    logic [31:0]                k_ext;
    logic [31:0]                t_ext;
    logic                       smp_we;
    logic                       tap_we;
    mac_ctrl_t                  mac_ctrl;
    logic signed [SAMPLE_WIDTH-1:0] smp_rd;
    logic signed [COEF_W-1:0]   g_rd;
    logic signed [COEF_W-1:0]   h_rd;
    logic                       mac_busy;
    logic signed [SAMPLE_WIDTH-1:0] mac_v;
    logic signed [SAMPLE_WIDTH-1:0] mac_w;
    logic                       mac_sat;

    assign idx_ext = 32'(index);
    assign k_ext   = 32'(k_reg);
    assign t_ext   = 32'(t_reg);

    // Loads outside the store depth are dropped.
    assign smp_we = in_acc && (req_type == REQ_SAMPLE) && (idx_ext < MAX_SERIES);
    assign tap_we = in_acc && (req_type == REQ_COEF) && (idx_ext < MAX_TAPS);

    assign mac_ctrl.clear = (state_reg == ST_NEG);
    assign mac_ctrl.issue = (state_reg == ST_WALK);

    mpw_store #(
        .MAX_SERIES   (MAX_SERIES),
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SA_W         (SA_W),
        .TA_W         (TA_W)
    ) u_store (
        .clk       (clk),
        .smp_we    (smp_we),
        .smp_waddr (idx_ext[SA_W-1:0]),
        .smp_wdata (sample),
        .tap_we    (tap_we),
        .tap_waddr (idx_ext[TA_W-1:0]),
        .g_wdata   (g_coef),
        .h_wdata   (h_coef),
        .rd_en     (mac_ctrl.issue),
        .smp_raddr (k_ext[SA_W-1:0]),
        .tap_raddr (l_reg),
        .smp_rdata (smp_rd),
        .g_rdata   (g_rd),
        .h_rdata   (h_rd)
    );

    mpw_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_TAPS     (MAX_TAPS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .smp   (smp_rd),
        .g     (g_rd),
        .h     (h_rd),
        .busy  (mac_busy),
        .v_out (mac_v),
        .w_out (mac_w),
        .sat   (mac_sat)
    );

    // ------------------------------------------------------------------
    // Sequencer next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        taps_m1_next   = taps_m1_reg;
        r_next         = r_reg;
        step_next      = step_reg;
        nstep_next     = nstep_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        l_next         = l_reg;
        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        sat_next       = sat_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Settings are captured here; they only change while idle.
                if (in_acc && (req_type == REQ_COMPUTE))
                begin
                    state_next   = ST_STEP;
                    cnt_next     = CNT_W'(lv_eff - LVL_W'(1));
                    first_next   = 1'b1;
                    r_next       = '0;
                    idx_next     = index;
                    n_next       = n_eff;
                    taps_m1_next = taps_m1_eff;
                end
            end
            ST_STEP:
            begin
                r_next     = am_res;
                first_next = 1'b0;
                if (cnt_reg == '0)
                begin
                    step_next  = am_res;
                    r_next     = '0;
                    cnt_next   = CNT_W'(POS_W - 1);
                    state_next = ST_POS;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_POS:
            begin
                r_next   = am_res;
                idx_next = idx_reg << 1;
                if (cnt_reg == '0)
                begin
                    t_next     = am_res;
                    k_next     = am_res;
                    state_next = ST_NEG;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_NEG:
            begin
                // Stepping back by tau equals stepping forward by n - tau.
                nstep_next = n_reg - NW'(step_reg);
                l_next     = '0;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                k_next = am_res;
                if (l_reg == taps_m1_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    l_next = l_reg + TA_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    pos_next       = t_ext[POS_W-1:0];
                    v_next         = mac_v;
                    w_next         = mac_w;
                    sat_next       = mac_sat;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        first_reg   <= first_next;
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        taps_m1_reg <= taps_m1_next;
        r_reg       <= r_next;
        step_reg    <= step_next;
        nstep_reg   <= nstep_next;
        k_reg       <= k_next;
        t_reg       <= t_next;
        l_reg       <= l_next;
        pos_reg     <= pos_next;
        v_reg       <= v_next;
        w_reg       <= w_next;
        sat_reg     <= sat_next;
    end

    assign out_valid   = out_valid_reg;
    assign position    = pos_reg;
    assign scaling_out = v_reg;
    assign wavelet_out = w_reg;
    assign saturated   = sat_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mpw_addmod.sv =====
// ----------------------------------------------------------------------------
// mpw_addmod
// Shared modular adder: (a + b) mod n for a + b below 2n.
// ----------------------------------------------------------------------------
`default_nettype none

module mpw_addmod #(
    parameter int KW = 10,
    parameter int NW = 11
) (
    input  wire logic [KW-1:0] a,
    input  wire logic [NW-1:0] b,
    input  wire logic [NW-1:0] n,
    output logic      [KW-1:0] res
);

    logic [NW:0] sum;
    logic [NW:0] diff;

    assign sum  = (NW+1)'(a) + (NW+1)'(b);
    assign diff = sum - (NW+1)'(n);

    // The result is always below n, so it fits the index width.
    assign res = (sum >= (NW+1)'(n)) ? diff[KW-1:0] : sum[KW-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/mpw_store.sv =====
// ----------------------------------------------------------------------------
// mpw_store
// Sample memory and coefficient tables with registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module mpw_store #(
    parameter int MAX_SERIES   = 1024,
    parameter int MAX_TAPS     = 16,
    parameter int SAMPLE_WIDTH = 16,
    parameter int SA_W         = 10,
    parameter int TA_W         = 4
) (
    input  wire logic                              clk,
    input  wire logic                              smp_we,
    input  wire logic [SA_W-1:0]                   smp_waddr,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    smp_wdata,
    input  wire logic                              tap_we,
    input  wire logic [TA_W-1:0]                   tap_waddr,
    input  wire logic signed [mpw_pkg::COEF_W-1:0] g_wdata,
    input  wire logic signed [mpw_pkg::COEF_W-1:0] h_wdata,
    input  wire logic                              rd_en,
    input  wire logic [SA_W-1:0]                   smp_raddr,
    input  wire logic [TA_W-1:0]                   tap_raddr,
    output logic signed [SAMPLE_WIDTH-1:0]         smp_rdata,
    output logic signed [mpw_pkg::COEF_W-1:0]      g_rdata,
    output logic signed [mpw_pkg::COEF_W-1:0]      h_rdata
);

    import mpw_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] smp_mem [MAX_SERIES];
    logic signed [COEF_W-1:0]       g_mem   [MAX_TAPS];
    logic signed [COEF_W-1:0]       h_mem   [MAX_TAPS];

    always_ff @(posedge clk)
    begin
        if (smp_we)
        begin
            smp_mem[smp_waddr] <= smp_wdata;
        end
        if (rd_en)
        begin
            smp_rdata <= smp_mem[smp_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            g_mem[tap_waddr] <= g_wdata;
            h_mem[tap_waddr] <= h_wdata;
        end
        if (rd_en)
        begin
            g_rdata <= g_mem[tap_raddr];
            h_rdata <= h_mem[tap_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mpw_mac.sv =====
// ----------------------------------------------------------------------------
// mpw_mac
// Dual multiply-accumulate with round-half-up and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mpw_mac #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_TAPS     = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mpw_pkg::mac_ctrl_t                ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    smp,
    input  wire logic signed [mpw_pkg::COEF_W-1:0] g,
    input  wire logic signed [mpw_pkg::COEF_W-1:0] h,
    output logic                                   busy,
    output logic signed [SAMPLE_WIDTH-1:0]         v_out,
    output logic signed [SAMPLE_WIDTH-1:0]         w_out,
    output logic                                   sat
);

    import mpw_pkg::*;

    localparam int PW    = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W = PW + $clog2(MAX_TAPS);
    localparam int RW    = ACC_W + 1 - COEF_FRAC;
    localparam logic signed [ACC_W:0] HALF = (ACC_W+1)'(1) << (COEF_FRAC - 1);

    logic                    rd_vld_reg;
    logic                    rd_vld_next;
    logic                    prod_vld_reg;
    logic                    prod_vld_next;
    logic signed [PW-1:0]    pv_reg;
    logic signed [PW-1:0]    pw_reg;
    logic signed [ACC_W-1:0] accv_reg;
    logic signed [ACC_W-1:0] accv_next;
    logic signed [ACC_W-1:0] accw_reg;
    logic signed [ACC_W-1:0] accw_next;
    logic                    sat_v;
    logic                    sat_w;

    // Returns the saturation flag above the rounded, clipped value.
    function automatic logic [SAMPLE_WIDTH:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] q;
        logic [RW-1:0]         r;
        logic                  fits;
        logic [SAMPLE_WIDTH-1:0] val;
        q    = {acc[ACC_W-1], acc} + HALF;
        r    = q[ACC_W:COEF_FRAC];
        fits = (&r[RW-1:SAMPLE_WIDTH-1]) | ~(|r[RW-1:SAMPLE_WIDTH-1]);
        val  = fits ? r[SAMPLE_WIDTH-1:0] : {r[RW-1], {(SAMPLE_WIDTH-1){~r[RW-1]}}};
        return {~fits, val};
    endfunction

    assign rd_vld_next   = ctrl.issue;
    assign prod_vld_next = rd_vld_reg;

    always_comb
    begin
        accv_next = accv_reg;
        accw_next = accw_reg;
        if (ctrl.clear)
        begin
            accv_next = '0;
            accw_next = '0;
        end
        else if (prod_vld_reg)
        begin
            accv_next = accv_reg + ACC_W'(pv_reg);
            accw_next = accw_reg + ACC_W'(pw_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= rd_vld_next;
            prod_vld_reg <= prod_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pv_reg   <= PW'(g) * PW'(smp);
        pw_reg   <= PW'(h) * PW'(smp);
        accv_reg <= accv_next;
        accw_reg <= accw_next;
    end

    assign busy = rd_vld_reg | prod_vld_reg;
    assign {sat_v, v_out} = round_sat(accv_reg);
    assign {sat_w, w_out} = round_sat(accw_reg);
    assign sat = sat_v | sat_w;

endmodule

`default_nettype wire

// ===== hw/rtl/mpw_checker.sv =====
// ----------------------------------------------------------------------------
// mpw_checker
// Port-level checks on the pyramid step, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mpw_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic [mpw_pkg::REQ_W-1:0]          req_type,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic [mpw_pkg::POS_W-1:0]          position,
    input wire logic signed [SAMPLE_WIDTH-1:0]     scaling_out,
    input wire logic signed [SAMPLE_WIDTH-1:0]     wavelet_out,
    input wire logic                               saturated
);

    import mpw_pkg::*;

    // An accepted compute beat makes the block busy.
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_COMPUTE) |=> in_stall)
        else $error("compute beat did not make the block busy");

    // An accepted load beat leaves the block ready.
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_COEF || req_type == REQ_SAMPLE)
        |=> !in_stall)
        else $error("load beat left the block busy");

    // A new result only appears at the end of a compute.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a compute in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position)
        && $stable(scaling_out) && $stable(wavelet_out) && $stable(saturated))
        else $error("stalled result beat changed");

endmodule

bind modwt_forward_pyramid_step mpw_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_mpw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .position    (position),
    .scaling_out (scaling_out),
    .wavelet_out (wavelet_out),
    .saturated   (saturated)
);

`default_nettype wire
